// ----- rtl/core/alpha_weighted_downscale_defines.svh -----
// ----------------------------------------------------------------------------
// alpha_weighted_downscale_defines
// Assertion macros used by the downscaler top level. Each expects clk and rst
// in scope and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ALPHA_WEIGHTED_DOWNSCALE_DEFINES_SVH
`define ALPHA_WEIGHTED_DOWNSCALE_DEFINES_SVH

// condition that must hold at every clock edge
`define AWD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define AWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/awd_pkg.sv -----
// ----------------------------------------------------------------------------
// awd_pkg
// Types and constants shared by the alpha-weighted downscaler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package awd_pkg;

  // configuration port
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 13;
  localparam logic [CFG_ADDR_W-1:0] REG_VERTICAL_ONLY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

  // register and counter widths
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 12;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

  // pixel layout
  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int ALPHA_LSB = 24;
  localparam int NUM_CH    = 3;
  localparam int NUM_TAPS  = 4;

  // blend arithmetic
  localparam int PROD_W    = 16;
  localparam int SUM_A_W   = 10;
  localparam int NUM_W     = 18;
  localparam int REM_W     = 19;
  localparam int DSH_W     = 18;
  localparam int DIV_STEPS = 8;
  localparam int STEP_W    = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_BLEND
  } awd_state_t;

  typedef enum logic [1:0] {
    BL_IDLE,
    BL_SUM,
    BL_DIV,
    BL_DONE
  } awd_bl_state_t;

  typedef struct packed {
    logic start;
    logic vert;
  } awd_blend_req_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
  } awd_blend_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/awd_ram.sv -----
// ----------------------------------------------------------------------------
// awd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module awd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/awd_blend.sv -----
// ----------------------------------------------------------------------------
// awd_blend
// Alpha-weighted average of four pixels: registered products, sums, then a
// restoring divider with one lane per colour channel, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module awd_blend import awd_pkg::*; (
  input  logic                               clk,
  input  logic                               rst,
  input  awd_blend_req_t                     req,
  input  logic [NUM_TAPS-1:0][PIX_W-1:0]     pix,
  input  logic                               take,
  output awd_blend_rsp_t                     rsp
);

  awd_bl_state_t       bl_state;
  awd_bl_state_t       bl_state_next;
  logic [STEP_W-1:0]   step;
  logic                vert;
  logic [CH_W-1:0]     alpha [NUM_TAPS];
  logic [PROD_W-1:0]   prod [NUM_CH][NUM_TAPS];
  logic [SUM_A_W-1:0]  sum_a_c;
  logic [NUM_W-1:0]    num_c [NUM_CH];
  logic [REM_W-1:0]    rem [NUM_CH];
  logic [REM_W-1:0]    rem_step [NUM_CH];
  logic [NUM_CH-1:0]   ge;
  logic [CH_W-1:0]     quo [NUM_CH];
  logic [DSH_W-1:0]    dsh;
  logic [CH_W-1:0]     alpha_out;
  logic                zero_a;

  // state register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      bl_state <= BL_IDLE;
      step     <= '0;
    end else begin
      bl_state <= bl_state_next;
      if (bl_state == BL_DIV) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  // next state
  always_comb begin
    bl_state_next = bl_state;
    unique case (bl_state)
      BL_IDLE: if (req.start) bl_state_next = BL_SUM;
      BL_SUM:  bl_state_next = BL_DIV;
      BL_DIV:  if (step == STEP_W'(DIV_STEPS - 1)) bl_state_next = BL_DONE;
      BL_DONE: if (take) bl_state_next = BL_IDLE;
      default: bl_state_next = BL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.valid = 1'b0;
    rsp.pixel = {alpha_out,
                 zero_a ? '0 : quo[2],
                 zero_a ? '0 : quo[1],
                 zero_a ? '0 : quo[0]};
    unique case (bl_state)
      BL_DONE: rsp.valid = 1'b1;
      default: rsp.valid = 1'b0;
    endcase
  end

  // alpha and colour sums over the four taps
  always_comb begin
    sum_a_c = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      sum_a_c = sum_a_c + SUM_A_W'(alpha[k]);
    end
    for (int c = 0; c < NUM_CH; c++) begin
      num_c[c] = '0;
      for (int k = 0; k < NUM_TAPS; k++) begin
        num_c[c] = num_c[c] + NUM_W'(prod[c][k]);
      end
    end
  end

  // one restoring divide step per lane
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ge[c]       = rem[c] >= REM_W'(dsh);
      rem_step[c] = ge[c] ? rem[c] - REM_W'(dsh) : rem[c];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (bl_state)
      BL_IDLE: begin
        if (req.start) begin
          vert <= req.vert;
          for (int k = 0; k < NUM_TAPS; k++) begin
            alpha[k] <= pix[k][ALPHA_LSB +: CH_W];
            for (int c = 0; c < NUM_CH; c++) begin
              prod[c][k] <= PROD_W'(pix[k][CH_W*c +: CH_W]) *
                            PROD_W'(pix[k][ALPHA_LSB +: CH_W]);
            end
          end
        end
      end
      BL_SUM: begin
        // dividend 2*num + sum_a, divisor 2*sum_a aligned to quotient bit 7
        for (int c = 0; c < NUM_CH; c++) begin
          rem[c] <= (REM_W'(num_c[c]) << 1) + REM_W'(sum_a_c);
          quo[c] <= '0;
        end
        dsh    <= DSH_W'(sum_a_c) << (DIV_STEPS);
        zero_a <= (sum_a_c == '0);
        if (vert) begin
          alpha_out <= CH_W'((SUM_A_W'(sum_a_c) + SUM_A_W'(1)) >> 1);
        end else begin
          alpha_out <= CH_W'((SUM_A_W'(sum_a_c) + SUM_A_W'(2)) >> 2);
        end
      end
      BL_DIV: begin
        for (int c = 0; c < NUM_CH; c++) begin
          rem[c] <= rem_step[c];
          quo[c] <= {quo[c][CH_W-2:0], ge[c]};
        end
        dsh <= dsh >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/alpha_weighted_downscale.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_downscale
// Even-row pixels and pixels that only open a pair are taken with no result.
// A pixel that completes a block goes through two line-store reads (one in
// vertical mode), the product and sum stages and the 8-step divider.
// No new pixel is taken until that result has moved to the output register.
// Reset clears counters and control and loads width 2, height 2, full mode;
// the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alpha_weighted_downscale_defines.svh"

module alpha_weighted_downscale import awd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input pixels
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // pixel_in
  // output pixels
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // pixel_out
  output logic                  m_axis_tlast    // last_of_image
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

  awd_state_t               state;
  awd_state_t               state_next;
  logic                     vertical_only;
  logic [WIDTH_REG_W-1:0]   image_width;
  logic [HEIGHT_REG_W-1:0]  image_height;
  logic [CW-1:0]            column_count;
  logic [ROW_W-1:0]         row_count;
  logic [PIX_W-1:0]         held_left_pixel;
  logic [PIX_W-1:0]         bottom_pixel;
  logic [PIX_W-1:0]         top_left;
  logic [CW-1:0]            read_col;
  logic                     image_last;
  logic                     blend_vert;
  logic [WIDTH_REG_W-1:0]   w_even;
  logic [HEIGHT_REG_W-1:0]  h_even;
  logic [WCW-1:0]           w_eff;
  logic [HEIGHT_REG_W-1:0]  h_eff;
  logic                     end_row;
  logic                     end_img;
  logic                     in_acc;
  logic                     out_free;
  logic                     ram_we;
  logic                     ram_re;
  logic [CW-1:0]            ram_raddr;
  logic [PIX_W-1:0]         ram_rdata;
  awd_blend_req_t           blend_req;
  awd_blend_rsp_t           blend_rsp;
  logic                     rsp_take;
  logic [NUM_TAPS-1:0][PIX_W-1:0] blend_pix;

  function automatic logic [CW-1:0] store_index(input logic [CW-1:0] c);
    if ({1'b0, c} < (CW + 1)'(MAX_WIDTH)) begin
      store_index = c;
    end else begin
      store_index = CW'(MAX_WIDTH - 1);
    end
  endfunction

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_only <= 1'b0;
      image_width   <= WIDTH_REG_W'(2);
      image_height  <= HEIGHT_REG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_VERTICAL_ONLY: vertical_only <= cfg_data[0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // effective image size, even and clamped
  assign w_even = {image_width[WIDTH_REG_W-1:1], 1'b0};
  assign h_even = {image_height[HEIGHT_REG_W-1:1], 1'b0};

  always_comb begin
    if (w_even < WIDTH_REG_W'(2)) begin
      w_eff = WCW'(2);
    end else if (WCW'(w_even) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(w_even);
    end
    if (h_even < HEIGHT_REG_W'(2)) begin
      h_eff = HEIGHT_REG_W'(2);
    end else if (h_even > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = h_even;
    end
  end

  // a counter at or past the size counts as the last column or row
  assign end_row = (WCW'(column_count) + WCW'(1)) >= w_eff;
  assign end_img = end_row &&
                   ((HEIGHT_REG_W'(row_count) + HEIGHT_REG_W'(1)) >= h_eff);

  // position counters and left pixel of the current pair
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      held_left_pixel <= '0;
    end else if (in_acc) begin
      if (end_row) begin
        column_count <= '0;
        row_count    <= end_img ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
      if (row_count[0] && !vertical_only && !column_count[0]) begin
        held_left_pixel <= s_axis_tdata;
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bottom_pixel <= s_axis_tdata;
      read_col     <= column_count;
      image_last   <= end_img;
      blend_vert   <= vertical_only;
    end
    if (state == ST_RD_A) begin
      top_left <= ram_rdata;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && row_count[0]) begin
          if (vertical_only) begin
            state_next = ST_RD_B;
          end else if (column_count[0]) begin
            state_next = ST_RD_A;
          end
        end
      end
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_BLEND;
      ST_BLEND: if (blend_rsp.valid && out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: line-store reads, blend start, result hand-off
  always_comb begin
    s_axis_tready   = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = store_index(read_col);
    blend_req.start = 1'b0;
    blend_req.vert  = blend_vert;
    rsp_take        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_axis_tvalid && row_count[0] &&
                        (vertical_only || column_count[0]);
        ram_raddr     = vertical_only ? store_index(column_count)
                                      : store_index(column_count - CW'(1));
      end
      ST_RD_A: ram_re = 1'b1;
      ST_RD_B: blend_req.start = 1'b1;
      ST_BLEND: rsp_take = blend_rsp.valid && out_free;
      default: begin
      end
    endcase
  end

  // even rows go to the line store
  assign ram_we = in_acc && !row_count[0];

  awd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (store_index(column_count)),
    .wdata (s_axis_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // taps: top left, top right, bottom left, bottom right
  assign blend_pix[0] = blend_vert ? '0 : top_left;
  assign blend_pix[1] = ram_rdata;
  assign blend_pix[2] = blend_vert ? '0 : held_left_pixel;
  assign blend_pix[3] = bottom_pixel;

  awd_blend u_blend (
    .clk  (clk),
    .rst  (rst),
    .req  (blend_req),
    .pix  (blend_pix),
    .take (rsp_take),
    .rsp  (blend_rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rsp_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      m_axis_tdata <= blend_rsp.pixel;
      m_axis_tlast <= image_last;
    end
  end

  // checks
  `AWD_ASSERT_ALWAYS(a_rsp_in_blend, !blend_rsp.valid || state == ST_BLEND, "blend result outside blend state")
  `AWD_ASSERT_ALWAYS(a_ram_one_access, !(ram_we && ram_re), "line store read and written together")
  `AWD_ASSERT_NEXT(a_image_wrap, in_acc && end_img, column_count == '0 && row_count == '0, "counters not cleared after last pixel")

endmodule

`default_nettype wire
